// File: rtl/core/wap2d_pkg.sv
// Package for the 2-D window average pool: constants, register indexes, helpers.
// Used by wap2d_div and window_average_pool_2d.
package wap2d_pkg;
    localparam int MaxKernel  = 8;
    localparam int MaxWidth   = 1024;
    localparam int SampleBits = 16;
    localparam int KBits      = 3;   // row slot select
    localparam int ColBits    = 10;
    localparam int StoreDepth = MaxKernel * MaxWidth;
    localparam int AddrBits   = KBits + ColBits;
    localparam int SumBits    = SampleBits + 6;
    localparam int CntBits    = 7;

    localparam logic [2:0] RegKh  = 3'd0;
    localparam logic [2:0] RegKw  = 3'd1;
    localparam logic [2:0] RegSh  = 3'd2;
    localparam logic [2:0] RegSw  = 3'd3;
    localparam logic [2:0] RegPad = 3'd4;
    localparam logic [2:0] RegH   = 3'd5;
    localparam logic [2:0] RegW   = 3'd6;

    // kernel size 0 acts as 1, above 8 acts as 8
    function automatic logic [3:0] clamp_kernel(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v == 4'd0) r = 4'd1;
        else if (v > 4'd8) r = 4'd8;
        return r;
    endfunction

    function automatic logic [3:0] clamp_pad(input logic [2:0] v, input logic [3:0] k);
        logic [3:0] r;
        r = {1'b0, v};
        if (r > k - 4'd1) r = k - 4'd1;
        return r;
    endfunction

    function automatic logic [10:0] clamp_size(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        if (v == 11'd0) r = 11'd1;
        else if (v > 11'd1024) r = 11'd1024;
        return r;
    endfunction
endpackage

// File: rtl/core/wap2d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wap2d_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/wap2d_div.sv
// Restoring signed divider: window sum by sample count, quotient toward zero.
// Depends on wap2d_pkg.
module wap2d_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [wap2d_pkg::SumBits-1:0] i_sum,
    input  logic [wap2d_pkg::CntBits-1:0]        i_cnt,
    output logic                                 o_done,
    output logic signed [wap2d_pkg::SampleBits-1:0] o_quot
);
    localparam int SB = wap2d_pkg::SumBits;
    localparam int CB = wap2d_pkg::CntBits;

    logic [SB-1:0]       r_num;
    logic [CB:0]         r_rem;
    logic [CB-1:0]       r_den;
    logic                r_neg;
    logic [$clog2(SB+1)-1:0] r_step;
    logic                r_busy;
    logic                r_done;
    logic [CB:0]         n_rem;
    logic [CB:0]         n_sub;
    logic [SB-1:0]       n_q;

    always_comb begin
        n_rem = {r_rem[CB-1:0], r_num[SB-1]};
        n_sub = n_rem - {1'b0, r_den};
    end
    assign n_q = r_neg ? (~r_num + {{(SB-1){1'b0}}, 1'b1}) : r_num;

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_sum[SB-1] ? (~i_sum + {{(SB-1){1'b0}}, 1'b1}) : i_sum;
                r_neg  <= i_sum[SB-1];
                r_den  <= i_cnt;
                r_rem  <= '0;
                r_step <= '0;
            end else if (r_busy) begin
                if (!n_sub[CB]) begin
                    r_rem <= n_sub;
                    r_num <= {r_num[SB-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_num <= {r_num[SB-2:0], 1'b0};
                end
                r_step <= r_step + 1'b1;
                if (r_step == $bits(r_step)'(SB-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = n_q[wap2d_pkg::SampleBits-1:0];
endmodule

// File: rtl/core/window_average_pool_2d.sv
// Top level of the 2-D window average pool (padding excluded from the count).
// Depends on wap2d_pkg, wap2d_ram and wap2d_div.
//
// Usage:
//   Input channel i_valid/o_stall carries one signed sample per transaction,
//   raster order over a plane of in_height x in_width; planes repeat.
//   Output channel o_valid/i_stall carries one window average per transaction
//   with its row, column, sample count and a last flag marking the final
//   window completed by the current input sample.
//   Configuration: i_cfg_we, i_cfg_addr, i_cfg_data; a write to addresses 0 to 6
//   restarts the plane at row 0 column 0. Write only while idle.
// Timing:
//   The input stalls from acceptance until the last window of the sample has
//   entered the output register. Each candidate origin that is not a window
//   passes through S_CAND and S_STEP; there is one candidate, or up to 64 on
//   the last row or column with bottom/right pad. A window takes one line
//   store read per sample in S_READ, then S_DRAIN, the divider and S_STEP,
//   and then the move to the output register, which waits while that
//   register is full and i_stall is high.
// Reset: synchronous active-low; registers return to defaults (2x2 kernel,
//   stride 2, no pad, 8x8 plane) and position to zero. The line store has
//   no reset; only entries written in the current plane are read.
module window_average_pool_2d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_average,
    output logic [10:0] o_out_row,
    output logic [10:0] o_out_col,
    output logic [6:0]  o_samples_counted,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_data
);
    localparam int AB = wap2d_pkg::AddrBits;
    localparam int SB = wap2d_pkg::SumBits;

    typedef enum logic [2:0] {
        S_IDLE, S_CAND, S_READ, S_DRAIN, S_DIV, S_STEP, S_OUT
    } t_state;

    // window origin along one axis: origin, origin mod stride, origin / stride (both zero while negative)
    typedef struct packed {
        logic signed [11:0] o;
        logic [3:0]         rem;
        logic [10:0]        q;
    } t_axis;

    // origin one position further, quotient and remainder kept in step
    function automatic t_axis axis_inc(input t_axis a, input logic [3:0] s);
        t_axis res;
        res = a;
        res.o = a.o + 12'sd1;
        if (a.o[11]) begin
            res.rem = '0;
            res.q   = '0;
        end else if (a.rem == s - 4'd1) begin
            res.rem = '0;
            res.q   = a.q + 11'd1;
        end else begin
            res.rem = a.rem + 4'd1;
        end
        return res;
    endfunction

    t_state r_state;
    logic [3:0]  r_kh, r_kw, r_sh, r_sw;
    logic [11:0] r_pad;
    logic [10:0] r_h, r_w;
    logic [9:0]  r_row, r_col;
    t_axis       r_prow, r_pcol;    // origin state of the next row / column

    // clamped config
    logic [3:0]  kh, kw, sh, sw, pt, pl, pb, pr;
    logic [10:0] hh, ww;
    assign kh = wap2d_pkg::clamp_kernel(r_kh);
    assign kw = wap2d_pkg::clamp_kernel(r_kw);
    assign sh = (r_sh == 4'd0) ? 4'd1 : r_sh;
    assign sw = (r_sw == 4'd0) ? 4'd1 : r_sw;
    assign pt = wap2d_pkg::clamp_pad(r_pad[2:0], kh);
    assign pl = wap2d_pkg::clamp_pad(r_pad[5:3], kw);
    assign pb = wap2d_pkg::clamp_pad(r_pad[8:6], kh);
    assign pr = wap2d_pkg::clamp_pad(r_pad[11:9], kw);
    assign hh = wap2d_pkg::clamp_size(r_h);
    assign ww = wap2d_pkg::clamp_size(r_w);

    // current item and candidate scan
    logic [9:0]  r_r, r_c;          // this sample's row/col
    logic [3:0]  r_dr, r_dc;        // pad offsets of the candidate
    logic [3:0]  r_xr, r_xc;        // pad span on each axis
    t_axis       r_ra, r_ca;        // candidate origins
    t_axis       r_cb;              // column origin at offset zero
    logic        r_fin;             // scan finished

    // window under work
    logic [9:0]  r_y, r_x, r_x0;
    logic [6:0]  r_cnt;
    logic signed [SB-1:0] r_sum;
    logic        r_rv;              // read data valid

    // finished window waiting to learn whether it is the last one
    logic        r_held;
    logic [15:0] r_havg;
    logic [10:0] r_hrow, r_hcol;
    logic [6:0]  r_hcnt;

    // output register
    logic [15:0] r_avg;
    logic [10:0] r_orow, r_ocol;
    logic [6:0]  r_ocnt;
    logic        r_olast;
    logic        r_ovalid;

    logic        accept, out_load, okr, okc, last_cand;
    t_axis       row_init, col_init, cur_row, cur_col;
    logic signed [11:0] ty, tx;
    logic [9:0]  y0, x0;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    // origin at the first row or column of a plane
    assign row_init = '{o: $signed({8'b0, pt}) - $signed({8'b0, kh}) + 12'sd1,
                        rem: 4'd0, q: 11'd0};
    assign col_init = '{o: $signed({8'b0, pl}) - $signed({8'b0, kw}) + 12'sd1,
                        rem: 4'd0, q: 11'd0};
    assign cur_row  = (r_row == 10'd0) ? row_init : r_prow;
    assign cur_col  = (r_col == 10'd0) ? col_init : r_pcol;

    // candidate is a window when its origin is in range and on the stride
    assign okr = !r_ra.o[11] && (r_ra.rem == 4'd0);
    assign okc = !r_ca.o[11] && (r_ca.rem == 4'd0);
    assign last_cand = (r_dr == r_xr) && (r_dc == r_xc);

    // first in-bounds row and column; the last ones are this sample's
    assign ty = r_ra.o - $signed({8'b0, pt});
    assign tx = r_ca.o - $signed({8'b0, pl});
    assign y0 = ty[11] ? 10'd0 : ty[9:0];
    assign x0 = tx[11] ? 10'd0 : tx[9:0];

    // line store
    logic            we;
    logic [AB-1:0]   waddr, raddr;
    logic [15:0]     rdata;
    assign we    = accept;
    assign waddr = {r_row[2:0], r_col};
    assign raddr = {r_y[2:0], r_x};

    wap2d_ram #(.Width(16), .Depth(wap2d_pkg::StoreDepth)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_sample),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic        div_start, div_done;
    logic [15:0] quot;
    wap2d_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_sum(r_sum),
        .i_cnt(r_cnt), .o_done(div_done), .o_quot(quot)
    );
    assign div_start = (r_state == S_DRAIN) && !r_rv;

    // configuration registers and sample position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kh <= 4'd2; r_kw <= 4'd2; r_sh <= 4'd2; r_sw <= 4'd2;
            r_pad <= 12'd0; r_h <= 11'd8; r_w <= 11'd8;
            r_row <= '0; r_col <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                wap2d_pkg::RegKh:  r_kh  <= i_cfg_data[3:0];
                wap2d_pkg::RegKw:  r_kw  <= i_cfg_data[3:0];
                wap2d_pkg::RegSh:  r_sh  <= i_cfg_data[3:0];
                wap2d_pkg::RegSw:  r_sw  <= i_cfg_data[3:0];
                wap2d_pkg::RegPad: r_pad <= i_cfg_data;
                wap2d_pkg::RegH:   r_h   <= i_cfg_data[10:0];
                wap2d_pkg::RegW:   r_w   <= i_cfg_data[10:0];
                default: ;
            endcase
            if (i_cfg_addr <= wap2d_pkg::RegW) begin
                r_row <= '0; r_col <= '0;
            end
        end else if (accept) begin
            // advance position, wrapping at plane size
            if ({1'b0, r_col} + 11'd1 >= ww) begin
                r_col  <= '0;
                r_row  <= ({1'b0, r_row} + 11'd1 >= hh) ? 10'd0 : r_row + 10'd1;
                r_prow <= axis_inc(cur_row, sh);
            end else begin
                r_col  <= r_col + 10'd1;
                r_pcol <= axis_inc(cur_col, sw);
            end
        end
    end

    // sequencer: scan candidates, sum each window, divide, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_held   <= 1'b0;
            r_fin    <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            r_rv <= (r_state == S_READ);
            if (r_rv) begin
                r_sum <= r_sum + $signed({{(SB-16){rdata[15]}}, rdata});
            end else if (r_state == S_CAND) begin
                r_sum <= '0;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_r   <= r_row;
                        r_c   <= r_col;
                        r_dr  <= '0; r_dc <= '0;
                        r_xr  <= ({1'b0, r_row} == hh - 11'd1) ? pb : 4'd0;
                        r_xc  <= ({1'b0, r_col} == ww - 11'd1) ? pr : 4'd0;
                        r_ra  <= cur_row;
                        r_ca  <= cur_col;
                        r_cb  <= cur_col;
                        r_fin <= 1'b0;
                        r_state <= S_CAND;
                    end
                end
                S_CAND: begin
                    if (okr && okc) begin
                        if (r_held) begin
                            // a later window exists, so the held one is not last
                            r_state <= S_OUT;
                        end else begin
                            r_y   <= y0;
                            r_x   <= x0;
                            r_x0  <= x0;
                            r_cnt <= '0;
                            r_state <= S_READ;
                        end
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_READ: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_x == r_c) begin
                        r_x <= r_x0;
                        if (r_y == r_r) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_y <= r_y + 10'd1;
                        end
                    end else begin
                        r_x <= r_x + 10'd1;
                    end
                end
                S_DRAIN: begin
                    if (div_start) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_havg  <= quot;
                        r_hrow  <= r_ra.q;
                        r_hcol  <= r_ca.q;
                        r_hcnt  <= r_cnt;
                        r_held  <= 1'b1;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (last_cand) begin
                        r_fin   <= 1'b1;
                        r_state <= r_held ? S_OUT : S_IDLE;
                    end else begin
                        if (r_dc == r_xc) begin
                            r_dc <= '0;
                            r_dr <= r_dr + 4'd1;
                            r_ra <= axis_inc(r_ra, sh);
                            r_ca <= r_cb;
                        end else begin
                            r_dc <= r_dc + 4'd1;
                            r_ca <= axis_inc(r_ca, sw);
                        end
                        r_state <= S_CAND;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_avg   <= r_havg;
                        r_orow  <= r_hrow;
                        r_ocol  <= r_hcol;
                        r_ocnt  <= r_hcnt;
                        r_olast <= r_fin;
                        r_held  <= 1'b0;
                        r_state <= r_fin ? S_IDLE : S_CAND;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_average = r_avg;
    assign o_out_row = r_orow;
    assign o_out_col = r_ocol;
    assign o_samples_counted = r_ocnt;
    assign o_last = r_olast;
endmodule
